@@ hw/rtl/ieee802154_rx_frame_filter_assert.svh @@
// Assertion macros for the 802.15.4 receive frame filter.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef IEEE802154_RX_FRAME_FILTER_ASSERT_SVH
`define IEEE802154_RX_FRAME_FILTER_ASSERT_SVH

// Checked on every rising clock edge while reset is released.
`define RXFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, also while reset is applied.
`define RXFF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/rxff_pkg.sv @@
// Shared types and constants of the 802.15.4 receive frame filter.
// No dependencies; imported by every module of the block.
package rxff_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegShortAddr    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegExtAddr      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPanId        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFramePending = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIsCoord      = 3'd4;

  localparam logic [15:0] ShortAddrReset = 16'hFFFE;
  localparam logic [15:0] BroadcastAddr  = 16'hFFFF;

  // Receiver status and length checks.
  localparam logic [7:0] CrcMask     = 8'h51;
  localparam logic [7:0] CrcOkValue  = 8'h10;
  localparam logic [8:0] LenOverhead = 9'd13;
  localparam logic [7:0] AckFrameLen = 8'd5;

  // Frame control fields.
  localparam logic [2:0] FtBeacon   = 3'd0;
  localparam logic [2:0] FtAck      = 3'd2;
  localparam logic [2:0] FtMaxValid = 3'd3;
  localparam int unsigned PendBit   = 4;
  localparam int unsigned AckReqBit = 5;
  localparam logic [7:0] DstModeMask  = 8'h0C;
  localparam logic [7:0] DstModeNone  = 8'h00;
  localparam logic [7:0] DstModeShort = 8'h08;
  localparam logic [7:0] DstModeExt   = 8'h0C;
  localparam logic [7:0] BeaconFcfHiA = 8'h80;
  localparam logic [7:0] BeaconFcfHiB = 8'hC0;
  localparam logic [7:0] AckCtrlBase  = 8'h02;

  typedef enum logic [3:0] {
    OUT_ACCEPTED   = 4'd0,
    OUT_ACK_DONE   = 4'd1,
    OUT_CRC_LEN    = 4'd2,
    OUT_BUSY       = 4'd3,
    OUT_EXPECT_ACK = 4'd4,
    OUT_BEACON     = 4'd5,
    OUT_PAN        = 4'd6,
    OUT_DST        = 4'd7,
    OUT_LEN        = 4'd8,
    OUT_TYPE       = 4'd9
  } outcome_e;

  typedef struct packed {
    logic        is_coordinator;
    logic        frame_pending;
    logic [15:0] pan_id;
    logic [63:0] ext_addr;
    logic [15:0] short_addr;
  } cfg_t;

  // Packed, so the first field sits in the highest bits and the last in the lowest.
  typedef struct packed {
    logic        busy_release;
    logic        waiting_ack;
    logic [63:0] dst_addr;
    logic [15:0] dst_pan;
    logic [7:0]  seq_num;
    logic [7:0]  fcf_high;
    logic [7:0]  fcf_low;
    logic [7:0]  crc_status;
    logic [7:0]  payload_len;
    logic [7:0]  dma_len;
  } item_t;

  typedef struct packed {
    logic [7:0] accepted_len;
    logic       peer_pending;
    logic [7:0] seq_out;
    logic [7:0] ack_frame_ctrl;
    logic       send_ack;
    outcome_e   outcome;
  } result_t;

  localparam int unsigned ItemW   = $bits(item_t);
  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned InDataW  = ((ItemW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

@@ hw/rtl/ieee802154_rx_frame_filter.sv @@
// A header accepted on s_axis waits in the item register; the verdict logic judges it into
// the result register that drives m_axis. Throughput: one header per cycle while m_axis is
// ready; each register is one stage, and the busy flag updates with the result register.
// Reset: clears both valid flags and the busy flag, and loads the configuration reset values
// (short address 0xFFFE, all other registers zero). No clearing pass is needed.
`include "ieee802154_rx_frame_filter_assert.svh"

module ieee802154_rx_frame_filter
  import rxff_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Frame headers in.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Low bit up: dma_len, payload_len, crc_status, fcf_low, fcf_high, seq_num,
  // dst_pan, dst_addr, waiting_ack, busy_release, zero fill.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // Verdicts out.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Low bit up: outcome, send_ack, ack_frame_ctrl, seq_out, peer_pending,
  // accepted_len, zero fill.
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_d, res_q;
  logic    res_vld_q;
  logic    busy_q, busy_d, busy_now;
  logic    accept;
  logic    advance;
  logic    in_xact;

  rxff_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held item moves to the result register when that register is free or drains.
  assign advance         = item_vld_q && (!res_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_vld_q || advance;
  assign in_xact         = s_axis_tvalid_i && s_axis_tready_o;

  // A release from the upper layer frees the receive path before this frame is judged.
  assign busy_now = item_q.busy_release ? 1'b0 : busy_q;

  rxff_decide u_decide (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .busy_i   (busy_now),
    .result_o (res_d),
    .accept_o (accept)
  );

  always_comb begin
    busy_d = busy_q;
    if (advance) begin
      busy_d = accept | busy_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      busy_q     <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (s_axis_tready_o) begin
        item_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      item_q <= item_t'(s_axis_tdata_i[ItemW-1:0]);
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResultW){1'b0}}, res_q};

  `RXFF_ASSERT(a_accept_sets_busy, advance && accept |=> busy_q,
               "accepted frame did not set the busy flag")
  `RXFF_ASSERT(a_release_clears_busy, advance && !accept && item_q.busy_release |=> !busy_q,
               "busy release followed by a drop left the busy flag set")
  `RXFF_ASSERT(a_ack_only_on_accept,
               res_vld_q && res_q.send_ack |-> res_q.outcome == OUT_ACCEPTED,
               "ACK requested for a frame that was not accepted")
  `RXFF_ASSERT_ALWAYS(a_stall_only_when_full,
                      !s_axis_tready_o |-> item_vld_q && res_vld_q && !m_axis_tready_i,
                      "input stalled while a register was free")

endmodule

@@ hw/rtl/rxff_cfg_regs.sv @@
// Configuration registers of the receive frame filter.
// Depends on rxff_pkg for the register indexes and the cfg_t layout.
module rxff_cfg_regs
  import rxff_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegShortAddr:    cfg_d.short_addr     = cfg_wdata_i[15:0];
        RegExtAddr:      cfg_d.ext_addr       = cfg_wdata_i;
        RegPanId:        cfg_d.pan_id         = cfg_wdata_i[15:0];
        RegFramePending: cfg_d.frame_pending  = cfg_wdata_i[0];
        RegIsCoord:      cfg_d.is_coordinator = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_addr     <= ShortAddrReset;
      cfg_q.ext_addr       <= '0;
      cfg_q.pan_id         <= '0;
      cfg_q.frame_pending  <= 1'b0;
      cfg_q.is_coordinator <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/rxff_decide.sv @@
// Verdict logic of the receive frame filter: one frame header in, one result out.
// Depends on rxff_pkg; purely combinational, sits between the item and result registers.
module rxff_decide
  import rxff_pkg::*;
(
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  input  logic    busy_i,
  output result_t result_o,
  output logic    accept_o
);

  logic       crc_ok, len_ok, pan_ok, dst_ok, beacon_ok;
  logic [2:0] ftype;
  logic [7:0] dst_mode;

  assign ftype    = item_i.fcf_low[2:0];
  assign dst_mode = item_i.fcf_high & DstModeMask;
  assign crc_ok   = (item_i.crc_status & CrcMask) == CrcOkValue;
  // The sum is one bit wider so that a large payload length cannot wrap.
  assign len_ok   = {1'b0, item_i.dma_len} == ({1'b0, item_i.payload_len} + LenOverhead);
  assign pan_ok   = (item_i.dst_pan == cfg_i.pan_id) || (item_i.dst_pan == BroadcastAddr);
  assign beacon_ok = (item_i.fcf_low == 8'h00) &&
                     (item_i.fcf_high inside {BeaconFcfHiA, BeaconFcfHiB});

  always_comb begin
    case (dst_mode)
      DstModeShort: dst_ok = (item_i.dst_addr[15:0] == BroadcastAddr) ||
                             (item_i.dst_addr[15:0] == cfg_i.short_addr);
      DstModeExt:   dst_ok = item_i.dst_addr == cfg_i.ext_addr;
      DstModeNone:  dst_ok = cfg_i.is_coordinator;
      default:      dst_ok = 1'b1;
    endcase
  end

  always_comb begin
    result_o = '0;
    accept_o = 1'b0;
    if (!crc_ok || !len_ok) begin
      result_o.outcome = OUT_CRC_LEN;
    end else if (item_i.waiting_ack) begin
      if (ftype != FtAck) begin
        result_o.outcome = OUT_EXPECT_ACK;
      end else if (item_i.payload_len != AckFrameLen) begin
        result_o.outcome = OUT_LEN;
      end else begin
        result_o.outcome      = OUT_ACK_DONE;
        result_o.seq_out      = item_i.seq_num;
        result_o.peer_pending = item_i.fcf_low[PendBit];
      end
    end else if (busy_i) begin
      result_o.outcome = OUT_BUSY;
    end else if (ftype > FtMaxValid) begin
      result_o.outcome = OUT_TYPE;
    end else if (ftype == FtBeacon && !beacon_ok) begin
      result_o.outcome = OUT_BEACON;
    end else if (ftype != FtBeacon && !pan_ok) begin
      result_o.outcome = OUT_PAN;
    end else if (ftype != FtBeacon && !dst_ok) begin
      result_o.outcome = OUT_DST;
    end else begin
      accept_o              = 1'b1;
      result_o.outcome      = OUT_ACCEPTED;
      result_o.accepted_len = item_i.payload_len;
      if (item_i.fcf_low[AckReqBit]) begin
        result_o.send_ack       = 1'b1;
        result_o.ack_frame_ctrl = AckCtrlBase | {3'b000, cfg_i.frame_pending, 4'b0000};
        result_o.seq_out        = item_i.seq_num;
      end
    end
  end

endmodule

@@ tb/ieee802154_rx_frame_filter_tb.sv @@
// Self-checking testbench for the 802.15.4 receive frame filter.
// Needs rxff_pkg and the filter top level; drives frame headers and checks each verdict
// against a directed expectation or an in-bench model, with random stalls on both stream sides.
`timescale 1ns / 1ps

module ieee802154_rx_frame_filter_tb
  import rxff_pkg::*;
();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseCount = 9;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned IdlePct    = 28;

  typedef struct {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [63:0]        val;
    item_t              frame;
    logic               typed;
    result_t            want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Shadow copy of the filter configuration and state.
  logic [15:0] own_short;
  logic [63:0] own_ext;
  logic [15:0] own_pan;
  logic        ack_pending_bit;
  logic        coord_mode;
  logic        busy_flag;

  result_t     verdicts_due[$];
  stim_row_t   rows[$];
  int          n_err;
  int unsigned cycle_cnt;
  logic        calm;

  ieee802154_rx_frame_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Verdict for one frame header; updates the busy flag like the block does.
  function automatic result_t predict_verdict(item_t f);
    result_t     r;
    logic [2:0]  ftype;
    logic [7:0]  mode;
    r = '0;
    r.outcome = OUT_ACCEPTED;
    ftype = f.fcf_low[2:0];
    mode = f.fcf_high & DstModeMask;
    if (f.busy_release) busy_flag = 1'b0;
    if ((f.crc_status & CrcMask) != CrcOkValue ||
        {1'b0, f.dma_len} != {1'b0, f.payload_len} + LenOverhead) begin
      r.outcome = OUT_CRC_LEN;
      return r;
    end
    if (f.waiting_ack) begin
      if (ftype != FtAck) r.outcome = OUT_EXPECT_ACK;
      else if (f.payload_len != AckFrameLen) r.outcome = OUT_LEN;
      else begin
        r.outcome = OUT_ACK_DONE;
        r.seq_out = f.seq_num;
        r.peer_pending = f.fcf_low[PendBit];
      end
      return r;
    end
    if (busy_flag) begin
      r.outcome = OUT_BUSY;
      return r;
    end
    if (ftype > FtMaxValid) begin
      r.outcome = OUT_TYPE;
      return r;
    end
    if (ftype == FtBeacon) begin
      if (f.fcf_low != 8'h00 || (f.fcf_high != BeaconFcfHiA && f.fcf_high != BeaconFcfHiB)) begin
        r.outcome = OUT_BEACON;
        return r;
      end
    end else begin
      if (f.dst_pan != own_pan && f.dst_pan != BroadcastAddr) begin
        r.outcome = OUT_PAN;
        return r;
      end
      // The reserved addressing mode passes the address filter.
      if ((mode == DstModeShort && f.dst_addr[15:0] != BroadcastAddr &&
           f.dst_addr[15:0] != own_short) ||
          (mode == DstModeExt && f.dst_addr != own_ext) ||
          (mode == DstModeNone && !coord_mode)) begin
        r.outcome = OUT_DST;
        return r;
      end
    end
    busy_flag = 1'b1;
    r.accepted_len = f.payload_len;
    if (f.fcf_low[AckReqBit]) begin
      r.send_ack = 1'b1;
      r.ack_frame_ctrl = AckCtrlBase | {3'b000, ack_pending_bit, 4'b0000};
      r.seq_out = f.seq_num;
    end
    return r;
  endfunction

  function automatic item_t mk_frame(logic [7:0] dlen, logic [7:0] plen, logic [7:0] crc,
                                     logic [7:0] f1, logic [7:0] f2, logic [7:0] seq,
                                     logic [15:0] dpan, logic [63:0] daddr,
                                     logic wack, logic rel);
    item_t f;
    f.dma_len = dlen;
    f.payload_len = plen;
    f.crc_status = crc;
    f.fcf_low = f1;
    f.fcf_high = f2;
    f.seq_num = seq;
    f.dst_pan = dpan;
    f.dst_addr = daddr;
    f.waiting_ack = wack;
    f.busy_release = rel;
    return f;
  endfunction

  function automatic result_t verdict(outcome_e o, logic ack, logic [7:0] ctrl,
                                      logic [7:0] seq, logic peer, logic [7:0] alen);
    result_t r;
    r.outcome = o;
    r.send_ack = ack;
    r.ack_frame_ctrl = ctrl;
    r.seq_out = seq;
    r.peer_pending = peer;
    r.accepted_len = alen;
    return r;
  endfunction

  function automatic stim_row_t frame_row(item_t f, logic typed, result_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.val = '0;
    row.frame = f;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    row.frame = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Mostly well-formed headers aimed at the deeper checks, the rest pure noise.
  function automatic item_t rand_frame();
    item_t        f;
    logic [159:0] raw;
    logic [2:0]   ft;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    f = raw[ItemW-1:0];
    if ($urandom_range(99) < 25) return f;
    f.crc_status = (f.crc_status & ~CrcMask) | CrcOkValue;
    f.payload_len = ($urandom_range(3) == 0) ? 8'($urandom_range(242)) : 8'($urandom_range(40));
    if ($urandom_range(19) != 0) f.dma_len = f.payload_len + 8'(LenOverhead);
    f.waiting_ack = ($urandom_range(99) < 15);
    ft = ($urandom_range(9) == 0) ? f.fcf_low[2:0] : 3'($urandom_range(3));
    if (f.waiting_ack && $urandom_range(3) != 0) begin
      ft = FtAck;
      if ($urandom_range(3) != 0) begin
        f.payload_len = AckFrameLen;
        f.dma_len = AckFrameLen + 8'(LenOverhead);
      end
    end
    f.fcf_low[2:0] = ft;
    if (ft == FtBeacon && $urandom_range(9) < 6) begin
      f.fcf_low = 8'h00;
      f.fcf_high = ($urandom_range(1) != 0) ? BeaconFcfHiA : BeaconFcfHiB;
    end
    case ($urandom_range(3))
      0, 1: f.dst_pan = own_pan;
      2: f.dst_pan = BroadcastAddr;
      default: ;
    endcase
    if ($urandom_range(1) != 0) begin
      f.dst_addr[15:0] = ($urandom_range(1) != 0) ? own_short : BroadcastAddr;
    end
    if ((f.fcf_high & DstModeMask) == DstModeExt && $urandom_range(1) != 0) f.dst_addr = own_ext;
    f.busy_release = ($urandom_range(99) < 55);
    return f;
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return BroadcastAddr;
      2: return ShortAddrReset;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; leaves the write enable high for a following write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      RegShortAddr:    own_short = val[15:0];
      RegExtAddr:      own_ext = val;
      RegPanId:        own_pan = val[15:0];
      RegFramePending: ack_pending_bit = val[0];
      RegIsCoord:      coord_mode = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_frame(item_t f, logic typed, result_t want);
    result_t p;
    cfg_we_i <= 1'b0;
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{(InDataW - ItemW){1'b0}}, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    p = predict_verdict(f);
    verdicts_due.push_back(typed ? want : p);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o[ResultW-1:0]);
      if (verdicts_due.size() == 0) begin
        $error("verdict transaction with no frame outstanding");
        n_err++;
      end else begin
        exp = verdicts_due.pop_front();
        if (got.outcome !== exp.outcome) begin
          $error("outcome: expected %0d, got %0d", exp.outcome, got.outcome);
          n_err++;
        end
        if (got.send_ack !== exp.send_ack) begin
          $error("send_ack: expected %0d, got %0d", exp.send_ack, got.send_ack);
          n_err++;
        end
        if (got.ack_frame_ctrl !== exp.ack_frame_ctrl) begin
          $error("ack_frame_ctrl: expected %h, got %h", exp.ack_frame_ctrl, got.ack_frame_ctrl);
          n_err++;
        end
        if (got.seq_out !== exp.seq_out) begin
          $error("seq_out: expected %h, got %h", exp.seq_out, got.seq_out);
          n_err++;
        end
        if (got.peer_pending !== exp.peer_pending) begin
          $error("peer_pending: expected %0d, got %0d", exp.peer_pending, got.peer_pending);
          n_err++;
        end
        if (got.accepted_len !== exp.accepted_len) begin
          $error("accepted_len: expected %0d, got %0d", exp.accepted_len, got.accepted_len);
          n_err++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    calm = 1'b0;
    n_err = 0;
    own_short = ShortAddrReset;
    own_ext = '0;
    own_pan = '0;
    ack_pending_bit = 1'b0;
    coord_mode = 1'b0;
    busy_flag = 1'b0;

    // Directed rows start from the reset configuration.
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h00, 8'h01, 8'h08, 8'h11, 16'h0, 64'h0,
                                      1'b0, 1'b0), 1'b1, verdict(OUT_CRC_LEN, 0, 0, 0, 0, 0)));
    // Length sum that would wrap to the DMA length must still fail.
    rows.push_back(frame_row(mk_frame(8'd0, 8'd243, 8'h10, 8'h01, 8'h08, 8'h00, 16'h0, 64'h0,
                                      1'b0, 1'b0), 1'b1, verdict(OUT_CRC_LEN, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd255, 8'd242, 8'hBE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, '1,
                                      1'b0, 1'b1), 1'b1, verdict(OUT_TYPE, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd18, 8'd5, 8'h10, 8'h12, 8'h00, 8'hA5, 16'h0, 64'h0,
                                      1'b1, 1'b0), 1'b1, verdict(OUT_ACK_DONE, 0, 0, 8'hA5, 1, 0)));
    rows.push_back(frame_row(mk_frame(8'd18, 8'd5, 8'h10, 8'h01, 8'h00, 8'h33, 16'h0, 64'h0,
                                      1'b1, 1'b0), 1'b1, verdict(OUT_EXPECT_ACK, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd19, 8'd6, 8'h10, 8'h22, 8'h00, 8'h44, 16'h0, 64'h0,
                                      1'b1, 1'b0), 1'b1, verdict(OUT_LEN, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd33, 8'd20, 8'h10, 8'h00, 8'h80, 8'h55, 16'h1234, 64'h0,
                                      1'b0, 1'b0), 1'b1, verdict(OUT_ACCEPTED, 0, 0, 0, 0, 8'd20)));
    rows.push_back(frame_row(mk_frame(8'd14, 8'd1, 8'h10, 8'h01, 8'h08, 8'h66, 16'hFFFF,
                                      64'hFFFF, 1'b0, 1'b0), 1'b1,
                             verdict(OUT_BUSY, 0, 0, 0, 0, 0)));
    // An ACK is consumed even while the receive path is busy.
    rows.push_back(frame_row(mk_frame(8'd18, 8'd5, 8'h10, 8'h02, 8'h00, 8'h07, 16'h0, 64'h0,
                                      1'b1, 1'b0), 1'b1, verdict(OUT_ACK_DONE, 0, 0, 8'h07, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h00, 8'h40, 8'h00, 16'h0, 64'h0,
                                      1'b0, 1'b1), 1'b1, verdict(OUT_BEACON, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h20, 8'hC0, 8'h00, 16'h0, 64'h0,
                                      1'b0, 1'b0), 1'b1, verdict(OUT_BEACON, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h01, 8'h08, 8'h00, 16'h0001,
                                      64'hFFFE, 1'b0, 1'b0), 1'b1,
                             verdict(OUT_PAN, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd23, 8'd10, 8'h10, 8'h21, 8'h08, 8'h99, 16'hFFFF,
                                      64'hFFFF, 1'b0, 1'b0), 1'b1,
                             verdict(OUT_ACCEPTED, 1, AckCtrlBase, 8'h99, 0, 8'd10)));
    rows.push_back(frame_row(mk_frame(8'd15, 8'd2, 8'h10, 8'h01, 8'h88, 8'h12, 16'h0000,
                                      64'hABCD_0000_0000_FFFE, 1'b0, 1'b1), 1'b0, '0));
    rows.push_back(frame_row(mk_frame(8'd15, 8'd2, 8'h10, 8'h01, 8'h08, 8'h00, 16'h0, 64'h1234,
                                      1'b0, 1'b1), 1'b1, verdict(OUT_DST, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h21, 8'h0C, 8'h3C, 16'h0, 64'h0,
                                      1'b0, 1'b1), 1'b0, '0));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h01, 8'h0C, 8'h00, 16'h0, 64'h1,
                                      1'b0, 1'b1), 1'b1, verdict(OUT_DST, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h01, 8'h00, 8'h00, 16'h0, 64'h0,
                                      1'b0, 1'b1), 1'b1, verdict(OUT_DST, 0, 0, 0, 0, 0)));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h03, 8'h04, 8'h00, 16'h0, 64'hDEAD,
                                      1'b0, 1'b1), 1'b0, '0));
    rows.push_back(cfg_row(RegIsCoord, 64'd1));
    rows.push_back(cfg_row(RegFramePending, 64'd1));
    rows.push_back(cfg_row(RegPanId, 64'hBEEF));
    rows.push_back(cfg_row(RegShortAddr, 64'h1234));
    rows.push_back(cfg_row(RegExtAddr, 64'h0123_4567_89AB_CDEF));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h21, 8'h00, 8'h5A, 16'hBEEF, 64'h0,
                                      1'b0, 1'b1), 1'b0, '0));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h03, 8'h0C, 8'h00, 16'hBEEF,
                                      64'h0123_4567_89AB_CDEF, 1'b0, 1'b1), 1'b0, '0));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h01, 8'h08, 8'h00, 16'hBEEF,
                                      64'h1234, 1'b0, 1'b0), 1'b0, '0));
    rows.push_back(cfg_row(RegShortAddr, 64'hFFFF));
    rows.push_back(cfg_row(RegExtAddr, '1));
    rows.push_back(cfg_row(RegPanId, 64'hFFFF));
    rows.push_back(cfg_row(RegFramePending, 64'd0));
    rows.push_back(cfg_row(RegIsCoord, 64'd0));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h21, 8'h0C, 8'h01, 16'hFFFF, '1,
                                      1'b0, 1'b1), 1'b0, '0));
    rows.push_back(frame_row(mk_frame(8'd13, 8'd0, 8'h10, 8'h01, 8'h08, 8'h00, 16'h0000,
                                      64'hFFFF, 1'b0, 1'b1), 1'b0, '0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_frame(rows[i].frame, rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      write_reg(RegShortAddr, {48'h0, pick_id()});
      case ($urandom_range(2))
        0: write_reg(RegExtAddr, 64'h0);
        1: write_reg(RegExtAddr, '1);
        default: write_reg(RegExtAddr, {$urandom, $urandom});
      endcase
      write_reg(RegPanId, {48'h0, pick_id()});
      write_reg(RegFramePending, {63'h0, 1'($urandom_range(1))});
      write_reg(RegIsCoord, {63'h0, 1'($urandom_range(1))});
      // One phase runs with both sides streaming back to back.
      calm = (ph == 4);
      repeat (PhaseItems) send_frame(rand_frame(), 1'b0, '0);
      calm = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk_i);
    while (verdicts_due.size() != 0) begin
      void'(verdicts_due.pop_front());
      $error("frame verdict never arrived");
      n_err++;
    end
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
